>>> hdl/khc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_pkg
// Shared constants, types and helpers of the k-mer histogram counter.
// ----------------------------------------------------------------------------
package khc_pkg;

  localparam int unsigned KmerLen    = 8;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned BaseBits   = 2;
  localparam int unsigned KmerBits   = BaseBits * KmerLen;
  localparam int unsigned StoreDepth = 2 ** KmerBits;
  localparam int unsigned SeenLimit  = 2 * KmerLen - 1;
  localparam int unsigned SeenWidth  = $clog2(SeenLimit + 1);
  localparam int unsigned QueryWidth = 16;
  localparam int unsigned OutWidth   = 32;

  localparam int unsigned CmdDepth   = 4;
  localparam int unsigned CmdPtrW    = $clog2(CmdDepth);
  localparam int unsigned CmdCntW    = $clog2(CmdDepth + 1);
  localparam int unsigned OutDepth   = 4;
  localparam int unsigned OutPtrW    = $clog2(OutDepth);
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);

  localparam logic [63:0] OutMax     = 64'h0000_0000_FFFF_FFFF;

  typedef logic [BaseBits-1:0]   base_t;
  typedef logic [KmerBits-1:0]   kmer_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [SeenWidth-1:0]  seen_t;
  typedef logic [QueryWidth-1:0] query_t;
  typedef logic [OutWidth-1:0]   out_t;

  typedef enum logic {
    OpPush = 1'b0,
    OpRead = 1'b1
  } opcode_e;

  typedef struct packed {
    logic  is_read;
    kmer_t index;
  } cmd_t;

  // clamp a counter to the result field
  function automatic out_t count_to_out(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > OutMax) begin
      return '1;
    end
    return out_t'(wide);
  endfunction

endpackage

>>> hdl/khc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module khc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/khc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_front
// Accepts items, keeps the base window and chunk position, and turns each
// item into a counter increment, a counter read, or nothing.
// ----------------------------------------------------------------------------
module khc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic            opcode_i,
  input  khc_pkg::base_t  base_code_i,
  input  logic            chunk_start_i,
  input  logic            first_chunk_i,
  input  khc_pkg::query_t query_index_i,
  input  logic            q_full_i,
  input  logic            clearing_i,
  output logic            cmd_valid_o,
  output khc_pkg::cmd_t   cmd_o
);
  import khc_pkg::*;

  kmer_t win_q, win_d;
  seen_t seen_q, seen_d;
  logic  first_q, first_d;

  kmer_t win_base;
  seen_t seen_base;
  logic  first_eff;
  seen_t thresh;
  logic  accept;
  logic  is_read;
  logic  complete;

  assign full_o  = q_full_i | clearing_i;
  assign accept  = push_i & ~full_o;
  assign is_read = (opcode_e'(opcode_i) == OpRead);

  always_comb begin
    win_base  = chunk_start_i ? '0 : win_q;
    seen_base = chunk_start_i ? '0 : seen_q;
    first_eff = chunk_start_i ? first_chunk_i : first_q;
    win_d     = {win_base[KmerBits-BaseBits-1:0], base_code_i};
    seen_d    = (seen_base < seen_t'(SeenLimit)) ? seen_base + seen_t'(1) : seen_base;
    first_d   = first_eff;
    thresh    = first_eff ? seen_t'(KmerLen) : seen_t'(SeenLimit);
    complete  = (seen_d >= thresh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      seen_q  <= '0;
      first_q <= 1'b1;
    end else if (accept && !is_read) begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      first_q <= first_d;
    end
  end

  assign cmd_valid_o   = accept & (is_read | complete);
  assign cmd_o.is_read = is_read;
  assign cmd_o.index   = is_read ? kmer_t'(query_index_i) : win_d;

endmodule

>>> hdl/khc_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_cmd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module khc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  khc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output khc_pkg::cmd_t head_o
);
  import khc_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wptr_q, rptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + CmdPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CmdCntW'(1);
        2'b01:   cnt_q <= cnt_q - CmdCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CmdCntW'(CmdDepth)) |=> (cnt_q != '0))
    else $error("command queue lost its entries while full");

endmodule

>>> hdl/khc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_back
// Clears the histogram after reset, then carries out increments and reads
// as a two-stage read-modify-write with write forwarding; read results go
// to a small result queue.
// ----------------------------------------------------------------------------
module khc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  khc_pkg::cmd_t head_i,
  output logic          head_pop_o,
  output logic          clearing_o,
  output logic          empty_o,
  input  logic          pop_i,
  output khc_pkg::out_t count_value_o
);
  import khc_pkg::*;

  logic               clearing_q;
  kmer_t              clr_addr_q;

  logic               s1_valid_q;
  cmd_t               s1_cmd_q;

  logic               fwd_valid_q;
  kmer_t              fwd_addr_q;
  count_t             fwd_data_q;

  out_t               out_mem_q [OutDepth];
  logic [OutPtrW-1:0] out_wptr_q, out_rptr_q;
  logic [OutCntW-1:0] out_cnt_q;

  logic [OutCntW:0]   committed;
  logic               inflight_rd;
  logic               room;
  logic               issue;

  count_t             rdata;
  count_t             cur;
  count_t             inc_val;
  logic               s1_write;
  logic               ram_we;
  kmer_t              ram_waddr;
  count_t             ram_wdata;
  logic               out_push, out_pop;

  assign inflight_rd = s1_valid_q & s1_cmd_q.is_read;
  assign committed   = {1'b0, out_cnt_q} + {{OutCntW{1'b0}}, inflight_rd};
  assign room        = (committed < (OutCntW + 1)'(OutDepth));
  assign issue       = ~clearing_q & head_valid_i & (~head_i.is_read | room);
  assign head_pop_o  = issue;
  assign clearing_o  = clearing_q;

  khc_ram #(
    .Width (CountWidth),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (head_i.index),
    .rdata_o (rdata)
  );

  always_comb begin
    cur      = (fwd_valid_q && fwd_addr_q == s1_cmd_q.index) ? fwd_data_q : rdata;
    inc_val  = (cur == '1) ? cur : cur + count_t'(1);
    s1_write = s1_valid_q & ~s1_cmd_q.is_read;
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_write;
      ram_waddr = s1_cmd_q.index;
      ram_wdata = inc_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + kmer_t'(1);
        if (clr_addr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      s1_valid_q  <= issue;
      fwd_valid_q <= s1_write & ~clearing_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_cmd_q <= head_i;
    end
    fwd_addr_q <= s1_cmd_q.index;
    fwd_data_q <= inc_val;
  end

  // result queue
  assign out_push      = inflight_rd;
  assign out_pop       = pop_i & (out_cnt_q != '0);
  assign empty_o       = (out_cnt_q == '0);
  assign count_value_o = out_mem_q[out_rptr_q];

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wptr_q] <= count_to_out(cur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wptr_q <= '0;
      out_rptr_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (out_push) begin
        out_wptr_q <= out_wptr_q + OutPtrW'(1);
      end
      if (out_pop) begin
        out_rptr_q <= out_rptr_q + OutPtrW'(1);
      end
      unique case ({out_push, out_pop})
        2'b10:   out_cnt_q <= out_cnt_q + OutCntW'(1);
        2'b01:   out_cnt_q <= out_cnt_q - OutCntW'(1);
        default: out_cnt_q <= out_cnt_q;
      endcase
    end
  end

  a_no_issue_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !issue)
    else $error("command issued during histogram clear");

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed <= (OutCntW + 1)'(OutDepth))
    else $error("result queue overcommitted");

  a_fwd_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_write && !clearing_q) |=>
      (fwd_valid_q && fwd_addr_q == $past(s1_cmd_q.index)))
    else $error("forwarding register missed an increment");

endmodule

>>> hdl/kmer_histogram_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_histogram_counter
// Rolling k-mer window over a 2-bit base stream with a saturating histogram.
// ----------------------------------------------------------------------------
// Input channel: an item transfers when push is high and full is low. A push
// item (opcode 0) shifts one base into the window and, once the chunk holds a
// complete k-mer past the overlap region, increments that k-mer's counter.
// A read item (opcode 1) returns the counter at query_index.
// Result channel: the oldest read result sits on count_value_o while empty is
// low and transfers when pop is high.
// Throughput: one item per cycle while full is low, limited by the single store
// read port and the read-modify-write loop (repeated k-mers are forwarded).
// Path: a read result passes the command queue, the store read stage and the
// result queue; an increment is visible to any later read item.
// Reset: full stays high while the 4^KmerLen (65536) histogram entries are
// cleared one entry per cycle.
// Stalls: when pop is held low, results collect in a 4-entry queue; once it
// and the 4-entry command queue fill, full rises. Push items that only
// shift the window still wait for a command slot.
// ----------------------------------------------------------------------------
module kmer_histogram_counter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic            opcode_i,
  input  khc_pkg::base_t  base_code_i,
  input  logic            chunk_start_i,
  input  logic            first_chunk_i,
  input  khc_pkg::query_t query_index_i,
  output logic            empty,
  input  logic            pop,
  output khc_pkg::out_t   count_value_o
);
  import khc_pkg::*;

  logic q_full;
  logic clearing;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic head_pop;

  khc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .opcode_i      (opcode_i),
    .base_code_i   (base_code_i),
    .chunk_start_i (chunk_start_i),
    .first_chunk_i (first_chunk_i),
    .query_index_i (query_index_i),
    .q_full_i      (q_full),
    .clearing_i    (clearing),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  khc_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  khc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .clearing_o    (clearing),
    .empty_o       (empty),
    .pop_i         (pop),
    .count_value_o (count_value_o)
  );

endmodule
